### rtl/core/pbm_pkg.sv
// pbm_pkg: shared constants, codes and types of the packet buffer manager
// used by pbm_adjust and packet_buffer_manager; depends on nothing
package pbm_pkg;

   // pool geometry
   localparam int NUM_BUFFERS  = 64;
   localparam int BUFFER_BYTES = 2048;
   localparam int ID_W         = 6;
   localparam int CNT_W        = 7;
   localparam int LEN_W        = 12;
   localparam int CSR_IDX_W    = 1;

   // register reset values
   localparam logic [LEN_W-1:0] INIT_HEADROOM_RST = 12'd192;
   localparam logic [LEN_W-1:0] MIN_HEADROOM_RST  = 12'd64;

   // buffer memory word: free mark, offset, length
   localparam int BUF_W = 1 + 2 * LEN_W;

   typedef enum logic [2:0] {
      CMD_ALLOC        = 3'd0,
      CMD_FREE         = 3'd1,
      CMD_EXTEND_FRONT = 3'd2,
      CMD_EXTEND_BACK  = 3'd3,
      CMD_SHRINK_FRONT = 3'd4,
      CMD_SHRINK_BACK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_INVAL = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INIT_HEADROOM = 1'b0,
      CSR_MIN_HEADROOM  = 1'b1
   } csr_idx_type;

   // outcome of a payload adjust
   typedef struct packed {
      logic             ok;
      logic [LEN_W-1:0] offset;
      logic [LEN_W-1:0] length;
   } adjust_type;

endpackage

### rtl/core/packet_buffer_manager.sv
// packet_buffer_manager: an accepted request is registered, executed in S_EXEC, and its
// result strobe is registered; no new request is taken while busy, during the
// read-modify-write of the buffer and free-id memories; the receiver cannot stall.
// reset is synchronous: control state and valid bits clear at once, an unwritten
// memory entry reads as its reset value, so no clearing pass is run.
// depends on pbm_pkg, pbm_ram, pbm_adjust
module packet_buffer_manager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic [pbm_pkg::ID_W-1:0]      req_buffer_id,
   input  logic [pbm_pkg::LEN_W-1:0]     req_amount,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [pbm_pkg::ID_W-1:0]      rsp_result_id,
   output logic [pbm_pkg::LEN_W-1:0]     rsp_data_offset,
   output logic [pbm_pkg::LEN_W-1:0]     rsp_data_length,
   input  logic                          csr_we,
   input  logic [pbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbm_pkg::LEN_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   localparam int ID_W  = pbm_pkg::ID_W;
   localparam int LEN_W = pbm_pkg::LEN_W;
   localparam int CNT_W = pbm_pkg::CNT_W;

   state_type                    state_ff, state_in;
   pbm_pkg::cmd_type             cmd_ff;
   logic [ID_W-1:0]              id_ff;
   logic [LEN_W-1:0]             amount_ff;
   logic                         buf_vld_rd_ff;
   logic                         q_vld_rd_ff;
   logic [pbm_pkg::NUM_BUFFERS-1:0] buf_vld_ff;
   logic [pbm_pkg::NUM_BUFFERS-1:0] q_vld_ff;
   logic [ID_W-1:0]              head_ff, head_in;
   logic [ID_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [LEN_W-1:0]             init_headroom_ff;
   logic [LEN_W-1:0]             min_headroom_ff;
   logic                         accept;
   logic                         exec;

   logic [pbm_pkg::BUF_W-1:0]    buf_rdata;
   logic [pbm_pkg::BUF_W-1:0]    buf_wdata;
   logic                         buf_we;
   logic [ID_W-1:0]              buf_waddr;
   logic [ID_W-1:0]              q_rdata;
   logic                         q_we;

   logic                         cur_mark;
   logic [LEN_W-1:0]             cur_off;
   logic [LEN_W-1:0]             cur_len;
   logic [ID_W-1:0]              got_id;
   logic                         id_in_range;
   pbm_pkg::adjust_type          adj;

   logic                         rsp_valid_ff;
   logic [1:0]                   status_ff, status_in;
   logic [ID_W-1:0]              res_id_ff, res_id_in;
   logic [LEN_W-1:0]             res_off_ff, res_off_in;
   logic [LEN_W-1:0]             res_len_ff, res_len_in;

   assign accept = start && (state_ff == S_IDLE);
   assign exec   = (state_ff == S_EXEC);
   assign busy   = exec;

   // sequencer: accept then execute
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_headroom_ff <= pbm_pkg::INIT_HEADROOM_RST;
         min_headroom_ff  <= pbm_pkg::MIN_HEADROOM_RST;
      end else if (csr_we) begin
         unique case (pbm_pkg::csr_idx_type'(csr_index))
            pbm_pkg::CSR_INIT_HEADROOM: init_headroom_ff <= csr_wdata;
            pbm_pkg::CSR_MIN_HEADROOM:  min_headroom_ff  <= csr_wdata;
            default: begin
               init_headroom_ff <= init_headroom_ff;
            end
         endcase
      end
   end

   // request capture, no reset needed on payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= pbm_pkg::cmd_type'(req_cmd);
         id_ff         <= req_buffer_id;
         amount_ff     <= req_amount;
         buf_vld_rd_ff <= buf_vld_ff[req_buffer_id];
         q_vld_rd_ff   <= q_vld_ff[head_ff];
      end
   end

   // buffer state memory: free mark, offset, length
   pbm_ram #(
      .WIDTH (pbm_pkg::BUF_W),
      .DEPTH (pbm_pkg::NUM_BUFFERS)
   ) u_buf_ram (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .raddr (req_buffer_id),
      .rdata (buf_rdata)
   );

   // free id queue memory
   pbm_ram #(
      .WIDTH (ID_W),
      .DEPTH (pbm_pkg::NUM_BUFFERS)
   ) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (tail_ff),
      .wdata (id_ff),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   // unwritten entries read as their reset value
   always_comb begin
      if (buf_vld_rd_ff) begin
         {cur_mark, cur_off, cur_len} = buf_rdata;
      end else begin
         cur_mark = 1'b1;
         cur_off  = pbm_pkg::INIT_HEADROOM_RST;
         cur_len  = '0;
      end
      got_id = q_vld_rd_ff ? q_rdata : head_ff;
      if (!(CNT_W'(got_id) < CNT_W'(pbm_pkg::NUM_BUFFERS))) got_id = '0;
      id_in_range = CNT_W'(id_ff) < CNT_W'(pbm_pkg::NUM_BUFFERS);
   end

   pbm_adjust u_adjust (
      .cmd          (cmd_ff),
      .offset       (cur_off),
      .length       (cur_len),
      .amount       (amount_ff),
      .min_headroom (min_headroom_ff),
      .result       (adj)
   );

   // execute: write back, queue update and result
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      buf_we     = 1'b0;
      buf_waddr  = id_ff;
      buf_wdata  = {cur_mark, cur_off, cur_len};
      q_we       = 1'b0;
      status_in  = pbm_pkg::ST_OK;
      res_id_in  = id_ff;
      res_off_in = cur_off;
      res_len_in = cur_len;
      if (exec) begin
         if (cmd_ff == pbm_pkg::CMD_ALLOC) begin
            if (count_ff == '0) begin
               status_in  = pbm_pkg::ST_EMPTY;
               res_id_in  = '0;
               res_off_in = '0;
               res_len_in = '0;
            end else begin
               head_in    = (head_ff == ID_W'(pbm_pkg::NUM_BUFFERS - 1)) ? '0 : head_ff + 1'b1;
               count_in   = count_ff - 1'b1;
               buf_we     = 1'b1;
               buf_waddr  = got_id;
               buf_wdata  = {1'b0, init_headroom_ff, {LEN_W{1'b0}}};
               res_id_in  = got_id;
               res_off_in = init_headroom_ff;
               res_len_in = '0;
            end
         end else if (!id_in_range) begin
            status_in  = pbm_pkg::ST_INVAL;
            res_off_in = '0;
            res_len_in = '0;
         end else if (cmd_ff == pbm_pkg::CMD_FREE) begin
            if (!cur_mark && (count_ff < CNT_W'(pbm_pkg::NUM_BUFFERS))) begin
               q_we      = 1'b1;
               tail_in   = (tail_ff == ID_W'(pbm_pkg::NUM_BUFFERS - 1)) ? '0 : tail_ff + 1'b1;
               count_in  = count_ff + 1'b1;
               buf_we    = 1'b1;
               buf_wdata = {1'b1, cur_off, cur_len};
            end
         end else begin
            buf_we     = 1'b1;
            buf_wdata  = {cur_mark, adj.offset, adj.length};
            status_in  = adj.ok ? pbm_pkg::ST_OK : pbm_pkg::ST_INVAL;
            res_off_in = adj.offset;
            res_len_in = adj.length;
         end
      end
   end

   // control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= CNT_W'(pbm_pkg::NUM_BUFFERS);
         buf_vld_ff   <= '0;
         q_vld_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= exec;
         if (buf_we) buf_vld_ff[buf_waddr] <= 1'b1;
         if (q_we)   q_vld_ff[tail_ff]     <= 1'b1;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff  <= status_in;
         res_id_ff  <= res_id_in;
         res_off_ff <= res_off_in;
         res_len_ff <= res_len_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_id   = res_id_ff;
   assign rsp_data_offset = res_off_ff;
   assign rsp_data_length = res_len_ff;

`ifndef NO_ASSERTIONS
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("result strobe without an executed request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(pbm_pkg::NUM_BUFFERS))
      else $error("free count above pool size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (exec && cmd_ff == pbm_pkg::CMD_ALLOC && count_ff != '0)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("allocate did not take one id from the pool");
`endif

endmodule

### rtl/core/pbm_ram.sv
// pbm_ram: generic single write port, single read port ram with registered read
// no dependencies
module pbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/pbm_adjust.sv
// pbm_adjust: bounds checks and new offset and length for the four adjust commands
// depends on pbm_pkg
module pbm_adjust (
   input  pbm_pkg::cmd_type                cmd,
   input  logic [pbm_pkg::LEN_W-1:0]       offset,
   input  logic [pbm_pkg::LEN_W-1:0]       length,
   input  logic [pbm_pkg::LEN_W-1:0]       amount,
   input  logic [pbm_pkg::LEN_W-1:0]       min_headroom,
   output pbm_pkg::adjust_type             result
);

   logic [pbm_pkg::LEN_W-1:0] off_less;
   logic [pbm_pkg::LEN_W+1:0] back_end;
   logic                      amt_gt_off;
   logic                      amt_gt_len;

   // differences, sums and compares for the per command checks
   always_comb begin
      off_less   = offset - amount;
      back_end   = (pbm_pkg::LEN_W+2)'(offset) + (pbm_pkg::LEN_W+2)'(length)
                   + (pbm_pkg::LEN_W+2)'(amount);
      amt_gt_off = amount > offset;
      amt_gt_len = amount > length;
   end

   // per command check; a failed check keeps the buffer as it is
   always_comb begin
      result.ok     = 1'b0;
      result.offset = offset;
      result.length = length;
      unique case (cmd)
         pbm_pkg::CMD_EXTEND_FRONT: begin
            if (!amt_gt_off && !(off_less < min_headroom)) begin
               result.ok     = 1'b1;
               result.offset = off_less;
               result.length = length + amount;
            end
         end
         pbm_pkg::CMD_EXTEND_BACK: begin
            if (!(back_end > (pbm_pkg::LEN_W+2)'(pbm_pkg::BUFFER_BYTES))) begin
               result.ok     = 1'b1;
               result.length = length + amount;
            end
         end
         pbm_pkg::CMD_SHRINK_FRONT: begin
            if (!amt_gt_len) begin
               result.ok     = 1'b1;
               result.offset = offset + amount;
               result.length = length - amount;
            end
         end
         pbm_pkg::CMD_SHRINK_BACK: begin
            if (!amt_gt_len) begin
               result.ok     = 1'b1;
               result.length = length - amount;
            end
         end
         default: begin
            result.ok = 1'b0;
         end
      endcase
   end

endmodule
